>>> design/b58_pkg.sv
// Package for the base-58 encoder: sizes, arithmetic constants, payload types,
// controller states, the controller/datapath command and status structs and the alphabet.
// Depends on nothing; every other design file imports it.
package b58_pkg;

  localparam int MAX_BYTES    = 32;
  localparam int STORE_DIGITS = MAX_BYTES * 138 / 100 + 1;
  localparam int ADDR_W       = $clog2(STORE_DIGITS);
  localparam int CNT_W        = $clog2(STORE_DIGITS + 1);
  localparam int DIGIT_W      = 6;
  localparam int BYTE_W       = 8;
  localparam int BASE         = 58;
  localparam int CARRY_W      = 9;
  localparam int CARRY_MAX    = 256;
  localparam int ACC_W        = DIGIT_W + BYTE_W;
  localparam int RECIP_SHIFT  = 20;
  localparam int RECIP        = ((1 << RECIP_SHIFT) + BASE - 1) / BASE;
  localparam int RECIP_W      = 15;
  localparam int PROD_W       = ACC_W + RECIP_W;
  localparam int CHAR_W       = 7;
  localparam int CAP_W        = 7;
  localparam int CHK_W        = CNT_W + 2;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(65);
  localparam logic [CHAR_W-1:0] CHAR_ONE  = CHAR_W'(8'h31);
  localparam logic [CHAR_W-1:0] CHAR_NONE = '0;

  typedef enum logic [1:0] {
    B58_OK      = 2'd0,
    B58_ERR_CAP = 2'd1,
    B58_ERR_LEN = 2'd2
  } b58_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_FINISH,
    ST_ZERO,
    ST_DRD,
    ST_DOUT
  } b58_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } b58_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
    b58_status_e       status;
  } b58_out_t;

  typedef struct packed {
    logic accept;
    logic fold_step;
    logic rd_emit;
    logic load_zero;
    logic load_digit;
    logic load_error;
    logic clear_msg;
  } b58_cmd_t;

  typedef struct packed {
    logic fold_needed;
    logic in_last;
    logic fold_done;
    logic msg_last;
    logic err;
    logic lz_zero;
    logic lz_one;
    logic sig_zero;
    logic sig_one;
    logic out_free;
  } b58_sts_t;

  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] dd;
    dd = CHAR_W'(d);
    if (d < DIGIT_W'(9)) begin
      c = CHAR_W'(8'h31) + dd;
    end else if (d < DIGIT_W'(17)) begin
      c = CHAR_W'(8'h41) + dd - CHAR_W'(9);
    end else if (d < DIGIT_W'(22)) begin
      c = CHAR_W'(8'h4A) + dd - CHAR_W'(17);
    end else if (d < DIGIT_W'(33)) begin
      c = CHAR_W'(8'h50) + dd - CHAR_W'(22);
    end else if (d < DIGIT_W'(44)) begin
      c = CHAR_W'(8'h61) + dd - CHAR_W'(33);
    end else if (d < DIGIT_W'(BASE)) begin
      c = CHAR_W'(8'h6D) + dd - CHAR_W'(44);
    end else begin
      c = CHAR_ONE;
    end
    return c;
  endfunction

endpackage

>>> design/b58_ctrl.sv
// Controller state machine of the base-58 encoder: sequences byte intake, digit sweeps
// and character emission. Depends on b58_pkg; drives the datapath b58_dp by commands.
module b58_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  b58_pkg::b58_sts_t sts_i,
  output b58_pkg::b58_cmd_t cmd_o
);
  import b58_pkg::*;

  b58_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.fold_needed) begin
            state_d = ST_FOLD;
          end else if (sts_i.in_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FOLD: begin
        cmd_o.fold_step = 1'b1;
        if (sts_i.fold_done) begin
          state_d = sts_i.msg_last ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        cmd_o.rd_emit = 1'b1;
        if (sts_i.err) begin
          if (sts_i.out_free) begin
            cmd_o.load_error = 1'b1;
            cmd_o.clear_msg  = 1'b1;
            state_d          = ST_IDLE;
          end
        end else if (!sts_i.lz_zero) begin
          state_d = ST_ZERO;
        end else if (!sts_i.sig_zero) begin
          state_d = ST_DRD;
        end else begin
          cmd_o.clear_msg = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_ZERO: begin
        cmd_o.rd_emit = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load_zero = 1'b1;
          if (sts_i.lz_one) begin
            if (sts_i.sig_zero) begin
              cmd_o.clear_msg = 1'b1;
              state_d         = ST_IDLE;
            end else begin
              state_d = ST_DRD;
            end
          end
        end
      end
      ST_DRD: begin
        cmd_o.rd_emit = 1'b1;
        state_d       = ST_DOUT;
      end
      ST_DOUT: begin
        cmd_o.rd_emit = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load_digit = 1'b1;
          if (sts_i.sig_one) begin
            cmd_o.clear_msg = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            state_d = ST_DRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/b58_dp.sv
// Datapath of the base-58 encoder: digit memory, multiply-by-256 carry unit, message
// counters, capacity register and output register. Depends on b58_pkg; driven by b58_ctrl.
module b58_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  b58_pkg::b58_in_t            in_i,
  input  logic                        cfg_valid_i,
  input  logic [b58_pkg::CAP_W-1:0]   cfg_data_i,
  input  b58_pkg::b58_cmd_t           cmd_i,
  output b58_pkg::b58_sts_t           sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output b58_pkg::b58_out_t           out_o
);
  import b58_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DIGITS - 1);

  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   lz_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   sig_q;
  logic               seen_q;
  logic               ovf_q;
  logic               first_q;
  logic               last_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CARRY_W-1:0] carry_q;
  logic [DIGIT_W-1:0] mem_q [STORE_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;
  logic               out_valid_q;
  b58_out_t           out_q;

  logic               fold_needed;
  logic               cnt_full;
  logic [ADDR_W-1:0]  addr_d;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIGIT_W-1:0] dig_in;
  logic [ACC_W-1:0]   acc;
  logic [PROD_W-1:0]  prod;
  logic [CARRY_W-1:0] quot;
  logic [ACC_W-1:0]   rem_full;
  logic [DIGIT_W-1:0] rem;
  logic [CHK_W-1:0]   need;
  logic               out_free;

  assign cnt_full    = cnt_q >= CNT_W'(MAX_BYTES);
  assign fold_needed = !cnt_full && (seen_q || (in_i.data_byte != '0));
  assign addr_d      = (addr_q == LAST_ADDR) ? '0 : addr_q + ADDR_W'(1);

  assign dig_in   = first_q ? '0 : rd_data_q;
  assign acc      = {dig_in, {BYTE_W{1'b0}}} + ACC_W'(carry_q);
  assign prod     = PROD_W'(acc) * PROD_W'(RECIP);
  assign quot     = prod[RECIP_SHIFT +: CARRY_W];
  assign rem_full = acc - ACC_W'(quot) * ACC_W'(BASE);
  assign rem      = rem_full[DIGIT_W-1:0];

  assign need     = CHK_W'(lz_q) + CHK_W'(sig_q) + CHK_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rd_addr = '0;
    if (cmd_i.fold_step) begin
      rd_addr = addr_d;
    end else if (cmd_i.rd_emit && (sig_q != '0)) begin
      rd_addr = ADDR_W'(sig_q - CNT_W'(1));
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.fold_needed = fold_needed;
    sts_o.in_last     = in_i.last_byte;
    sts_o.fold_done   = addr_q == LAST_ADDR;
    sts_o.msg_last    = last_q;
    sts_o.err         = ovf_q || (CHK_W'(cap_q) < need);
    sts_o.lz_zero     = lz_q == '0;
    sts_o.lz_one      = lz_q == CNT_W'(1);
    sts_o.sig_zero    = sig_q == '0;
    sts_o.sig_one     = sig_q == CNT_W'(1);
    sts_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fold_step) begin
      mem_q[addr_q] <= rem;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lz_q    <= '0;
      cnt_q   <= '0;
      sig_q   <= '0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
      addr_q  <= '0;
      carry_q <= '0;
    end else if (cmd_i.clear_msg) begin
      lz_q   <= '0;
      cnt_q  <= '0;
      sig_q  <= '0;
      seen_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      last_q <= in_i.last_byte;
      if (cnt_full) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (fold_needed) begin
          first_q <= !seen_q;
          seen_q  <= 1'b1;
          carry_q <= CARRY_W'(in_i.data_byte);
          addr_q  <= '0;
        end else begin
          lz_q <= lz_q + CNT_W'(1);
        end
      end
    end else if (cmd_i.fold_step) begin
      carry_q <= quot;
      addr_q  <= addr_d;
      if (rem != '0) begin
        sig_q <= CNT_W'(addr_q) + CNT_W'(1);
      end
    end else if (cmd_i.load_zero) begin
      lz_q <= lz_q - CNT_W'(1);
    end else if (cmd_i.load_digit) begin
      sig_q <= sig_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_error || cmd_i.load_zero || cmd_i.load_digit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_error) begin
      out_q.out_char  <= CHAR_NONE;
      out_q.last_char <= 1'b1;
      out_q.status    <= ovf_q ? B58_ERR_LEN : B58_ERR_CAP;
    end else if (cmd_i.load_zero) begin
      out_q.out_char  <= CHAR_ONE;
      out_q.last_char <= (lz_q == CNT_W'(1)) && (sig_q == '0);
      out_q.status    <= B58_OK;
    end else if (cmd_i.load_digit) begin
      out_q.out_char  <= b58_char(rd_data_q);
      out_q.last_char <= sig_q == CNT_W'(1);
      out_q.status    <= B58_OK;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BYTES))
    else $error("Byte count exceeds the message limit.");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CNT_W'(MAX_BYTES)))
    else $error("Overflow flag set before the message limit was reached.");

  a_carry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold_step |-> (carry_q <= CARRY_W'(CARRY_MAX)))
    else $error("Carry out of range during a digit sweep.");

  a_digit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_digit |-> (sig_q != '0))
    else $error("Digit emitted with no significant digits left.");

endmodule

>>> design/base58_encoder.sv
// Base-58 encoder with the Bitcoin alphabet. Each message byte is one input
// transaction, most significant first, with the final byte marked; the result is one
// transaction per character with the final one marked, or a single error transaction.
// A leading zero byte, or a byte beyond the 32-byte limit, is taken without a sweep;
// every other byte makes the datapath sweep all 45 stored base-58 digits through
// one multiply-and-divide unit at one digit per cycle, reading the next digit of the
// memory while writing the current one.
// After the final byte, a finish state decides the outcome; each leading '1' then goes
// straight to the output register, each further character via a memory read first,
// and a stalled output waits. No clearing pass follows reset or a message.
// Depends on b58_pkg, b58_ctrl and b58_dp.
module base58_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  b58_pkg::b58_in_t          in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output b58_pkg::b58_out_t         out_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [b58_pkg::CAP_W-1:0] cfg_data_i
);
  import b58_pkg::*;

  b58_cmd_t cmd;
  b58_sts_t sts;

  assign cfg_ready_o = 1'b1;

  b58_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b58_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
